>>> sv/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// Shared constants, request and status codes, and the controller/datapath
// command and status bundles of the broadcast edge event queues.
// ----------------------------------------------------------------------------
`default_nettype none

package bee_pkg;

  // Fixed field widths
  localparam int unsigned ReqW  = 3;
  localparam int unsigned RidW  = 2;
  localparam int unsigned TsInW = 32;
  localparam int unsigned StW   = 2;

  // Parameter defaults
  localparam int unsigned NumReadersDef    = 4;
  localparam int unsigned QueueDepthDef    = 16;
  localparam int unsigned TimestampBitsDef = 32;

  // Request codes
  localparam logic [ReqW-1:0] REQ_OPEN   = 3'd0;
  localparam logic [ReqW-1:0] REQ_CLOSE  = 3'd1;
  localparam logic [ReqW-1:0] REQ_READ   = 3'd2;
  localparam logic [ReqW-1:0] REQ_FLUSH  = 3'd3;
  localparam logic [ReqW-1:0] REQ_INSERT = 3'd4;

  // Status codes
  localparam logic [StW-1:0] ST_OK        = 2'd0;
  localparam logic [StW-1:0] ST_UNREG     = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StW-1:0] ST_NOREADERS = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted word
    logic exec;        // decode and apply the latched request
    logic ins_step;    // append to one reader's queue
    logic rd_capture;  // take the registered memory read into the result
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exec_read;    // read hit, memory read issued this cycle
    logic exec_insert;  // insert request, reader sweep follows
    logic ins_last;     // sweep is at the last reader slot
    logic out_free;     // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

>>> sv/bee_ctrl.sv
// ----------------------------------------------------------------------------
// bee_ctrl
// Sequencer: accepts one word, runs the decode, the reader sweep of an
// insert or the memory read of a pop, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bee_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bee_pkg::sts_t sts_i,
  output bee_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS,
    S_RDW,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.exec_insert)    state_d = S_INS;
        else if (sts_i.exec_read) state_d = S_RDW;
        else                      state_d = S_DONE;
      end
      S_INS: begin
        if (sts_i.ins_last) state_d = S_DONE;
      end
      S_RDW: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  assign in_ready_o        = (state_q == S_IDLE);
  assign cmd_o.capture     = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec        = (state_q == S_EXEC);
  assign cmd_o.ins_step    = (state_q == S_INS);
  assign cmd_o.rd_capture  = (state_q == S_RDW);
  assign cmd_o.out_load    = (state_q == S_DONE) && sts_i.out_free;

  // Checks
  a_rd_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_capture |-> $past(sts_i.exec_read))
    else $error("read capture without an issued memory read");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("accepted word not decoded in the next cycle");

endmodule

`default_nettype wire

>>> sv/bee_dp.sv
// ----------------------------------------------------------------------------
// bee_dp
// Datapath: request register, per-reader registration, head and count,
// the event store memory and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bee_dp #(
  parameter int unsigned NUM_READERS    = bee_pkg::NumReadersDef,
  parameter int unsigned QUEUE_DEPTH    = bee_pkg::QueueDepthDef,
  parameter int unsigned TIMESTAMP_BITS = bee_pkg::TimestampBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bee_pkg::cmd_t              cmd_i,
  output bee_pkg::sts_t                   sts_o,
  input  wire logic [bee_pkg::ReqW-1:0]   req_type_i,
  input  wire logic [bee_pkg::RidW-1:0]   reader_id_i,
  input  wire logic [bee_pkg::TsInW-1:0]  timestamp_i,
  input  wire logic                       edge_rising_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bee_pkg::StW-1:0]         status_o,
  output logic                            event_valid_o,
  output logic [bee_pkg::TsInW-1:0]       event_timestamp_o,
  output logic                            event_rising_o
);

  localparam int unsigned RW    = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned KeepW = (TIMESTAMP_BITS < bee_pkg::TsInW) ?
                                  TIMESTAMP_BITS : bee_pkg::TsInW;
  localparam int unsigned EW    = KeepW + 1;

  // Request register
  logic [bee_pkg::ReqW-1:0] req_q;
  logic [bee_pkg::RidW-1:0] rid_q;
  logic [KeepW-1:0]         ts_q;
  logic                     rising_q;

  // Reader state
  logic [NUM_READERS-1:0] reg_q, reg_d;
  logic [PW-1:0]          head_q  [NUM_READERS];
  logic [PW-1:0]          head_d  [NUM_READERS];
  logic [CW-1:0]          count_q [NUM_READERS];
  logic [CW-1:0]          count_d [NUM_READERS];
  logic [RW-1:0]          idx_q;

  // Event store
  logic [EW-1:0] mem_q [NUM_READERS][QUEUE_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic          wr_en;
  logic [PW-1:0] wr_pos;
  logic [SW-1:0] wr_sum;

  // Result and output registers
  logic [bee_pkg::StW-1:0] res_status_q, res_status_d;
  logic                    res_valid_q, res_valid_d;
  logic [KeepW-1:0]        res_ts_q, res_ts_d;
  logic                    res_rising_q, res_rising_d;
  logic                    out_valid_q;
  logic [bee_pkg::StW-1:0] out_status_q;
  logic                    out_evalid_q;
  logic [KeepW-1:0]        out_ts_q;
  logic                    out_rising_q;

  logic          known;
  logic [RW-1:0] rid_ix;
  logic          reg_sel;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign known   = (32'(rid_q) < NUM_READERS);
  assign rid_ix  = RW'(rid_q);
  assign reg_sel = known && reg_q[rid_ix];

  // Latch the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      rid_q    <= reader_id_i;
      ts_q     <= timestamp_i[KeepW-1:0];
      rising_q <= edge_rising_i;
    end
  end

  // Request decode, reader sweep and result assembly
  always_comb begin
    reg_d              = reg_q;
    head_d             = head_q;
    count_d            = count_q;
    res_status_d       = res_status_q;
    res_valid_d        = res_valid_q;
    res_ts_d           = res_ts_q;
    res_rising_d       = res_rising_q;
    sts_o.exec_read    = 1'b0;
    sts_o.exec_insert  = 1'b0;
    sts_o.ins_last     = (idx_q == RW'(NUM_READERS - 1));
    sts_o.out_free     = !out_valid_q || out_ready_i;
    wr_en              = 1'b0;
    wr_pos             = '0;
    wr_sum             = SW'(head_q[idx_q]) + SW'(count_q[idx_q]);

    if (cmd_i.exec) begin
      res_status_d = bee_pkg::ST_OK;
      res_valid_d  = 1'b0;
      res_ts_d     = '0;
      res_rising_d = 1'b0;
      unique case (req_q)
        bee_pkg::REQ_OPEN: begin
          if (!known) begin
            res_status_d = bee_pkg::ST_UNREG;
          end else if (!reg_q[rid_ix]) begin
            reg_d[rid_ix]   = 1'b1;
            head_d[rid_ix]  = '0;
            count_d[rid_ix] = '0;
          end
        end
        bee_pkg::REQ_CLOSE: begin
          if (!reg_sel) begin
            res_status_d = bee_pkg::ST_UNREG;
          end else begin
            reg_d[rid_ix]   = 1'b0;
            head_d[rid_ix]  = '0;
            count_d[rid_ix] = '0;
          end
        end
        bee_pkg::REQ_FLUSH: begin
          if (!reg_sel) begin
            res_status_d = bee_pkg::ST_UNREG;
          end else begin
            head_d[rid_ix]  = '0;
            count_d[rid_ix] = '0;
          end
        end
        bee_pkg::REQ_READ: begin
          if (!reg_sel) begin
            res_status_d = bee_pkg::ST_UNREG;
          end else if (count_q[rid_ix] == '0) begin
            res_status_d = bee_pkg::ST_EMPTY;
          end else begin
            sts_o.exec_read = 1'b1;
            res_valid_d     = 1'b1;
            head_d[rid_ix]  = wrap_inc(head_q[rid_ix]);
            count_d[rid_ix] = count_q[rid_ix] - 1'b1;
          end
        end
        bee_pkg::REQ_INSERT: begin
          sts_o.exec_insert = 1'b1;
          res_status_d = (|reg_q) ? bee_pkg::ST_OK : bee_pkg::ST_NOREADERS;
        end
        default: ;  // unused codes: no change
      endcase
    end

    // One reader per cycle; a full queue overwrites its oldest entry
    if (cmd_i.ins_step && reg_q[idx_q]) begin
      wr_en = 1'b1;
      if (count_q[idx_q] == CW'(QUEUE_DEPTH)) begin
        wr_pos        = head_q[idx_q];
        head_d[idx_q] = wrap_inc(head_q[idx_q]);
      end else begin
        wr_pos         = (wr_sum >= SW'(QUEUE_DEPTH)) ?
                         PW'(wr_sum - SW'(QUEUE_DEPTH)) : PW'(wr_sum);
        count_d[idx_q] = count_q[idx_q] + 1'b1;
      end
    end

    if (cmd_i.rd_capture) begin
      res_ts_d     = rd_data_q[KeepW-1:0];
      res_rising_d = rd_data_q[KeepW];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q <= '0;
      for (int i = 0; i < NUM_READERS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      reg_q   <= reg_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.exec)          idx_q <= '0;
      else if (cmd_i.ins_step) idx_q <= idx_q + 1'b1;
      if (cmd_i.out_load)      out_valid_q <= 1'b1;
      else if (out_ready_i)    out_valid_q <= 1'b0;
    end
  end

  // Event store: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[idx_q][wr_pos] <= {rising_q, ts_q};
    if (sts_o.exec_read) rd_data_q <= mem_q[rid_ix][head_q[rid_ix]];
  end

  // Result and output payload
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_valid_q  <= res_valid_d;
    res_ts_q     <= res_ts_d;
    res_rising_q <= res_rising_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_evalid_q <= res_valid_q;
      out_ts_q     <= res_ts_q;
      out_rising_q <= res_rising_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign event_valid_o     = out_evalid_q;
  assign event_timestamp_o = bee_pkg::TsInW'(out_ts_q);
  assign event_rising_o    = out_rising_q;

  // Checks
  for (genvar g = 0; g < NUM_READERS; g++) begin : g_chk
    a_free_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !reg_q[g] |-> (count_q[g] == '0))
      else $error("free reader slot holds entries");

    a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[g] <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");
  end

  a_event_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_evalid_q) |-> (out_status_q == bee_pkg::ST_OK))
    else $error("event returned with a failing status");

endmodule

`default_nettype wire

>>> sv/broadcast_edge_event_queues.sv
// ----------------------------------------------------------------------------
// broadcast_edge_event_queues
// One bounded edge-event queue per reader slot, with open, close, read,
// flush and broadcast insert requests; one result word per request word.
// ----------------------------------------------------------------------------
// Words are handled one at a time. Open, close, flush and unused codes pass
// from acceptance through decode to the output hand-off; a read adds the
// registered event store read, and an insert a sweep that visits one reader
// slot per cycle, since the store has a single write port. A new word is
// accepted while the previous result still waits in the output register.
// The store needs no clearing after reset; only entries inside a queue's
// count are ever read.
`default_nettype none

module broadcast_edge_event_queues #(
  parameter int unsigned NUM_READERS    = bee_pkg::NumReadersDef,
  parameter int unsigned QUEUE_DEPTH    = bee_pkg::QueueDepthDef,
  parameter int unsigned TIMESTAMP_BITS = bee_pkg::TimestampBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bee_pkg::ReqW-1:0]   req_type_i,
  input  wire logic [bee_pkg::RidW-1:0]   reader_id_i,
  input  wire logic [bee_pkg::TsInW-1:0]  timestamp_i,
  input  wire logic                       edge_rising_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bee_pkg::StW-1:0]         status_o,
  output logic                            event_valid_o,
  output logic [bee_pkg::TsInW-1:0]       event_timestamp_o,
  output logic                            event_rising_o
);

  bee_pkg::cmd_t cmd;
  bee_pkg::sts_t sts;

  // Sequencer
  bee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Queues and result path
  bee_dp #(
    .NUM_READERS    (NUM_READERS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .reader_id_i       (reader_id_i),
    .timestamp_i       (timestamp_i),
    .edge_rising_i     (edge_rising_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .event_valid_o     (event_valid_o),
    .event_timestamp_o (event_timestamp_o),
    .event_rising_o    (event_rising_o)
  );

endmodule

`default_nettype wire
